// File: src/sems_pkg.sv
package sems_pkg;

  localparam int CFG_W   = 13;
  localparam int PIX_W   = 8;
  localparam int POS_W   = 12;
  localparam int GRAD_W  = 12;
  localparam int SUM_W   = 22;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [CFG_W-1:0] HEIGHT_MAX = 13'd4096;
  localparam logic [CFG_W-1:0] DIM_MIN    = 13'd3;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic take;
    logic rd;
    logic upd;
    logic sq;
    logic step;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic interior;
    logic root_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: src/sems_pix_if.sv
interface sems_pix_if import sems_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

// File: src/sems_res_if.sv
interface sems_res_if import sems_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] edge_res;
  logic [POS_W-1:0] center_col;
  logic [POS_W-1:0] center_row;
  logic             frame_last;

  modport source (output valid, output edge_res, output center_col, output center_row,
                  output frame_last, input ready);
  modport sink (input valid, input edge_res, input center_col, input center_row,
                input frame_last, output ready);
endinterface

// File: src/sems_ctrl.sv
module sems_ctrl import sems_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_GRAD,
    S_SQ,
    S_ROOT,
    S_OUT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_READ;
        S_READ: state <= S_GRAD;
        S_GRAD: state <= status.interior ? S_SQ : S_IDLE;
        S_SQ:   state <= S_ROOT;
        S_ROOT: if (status.root_last) state <= S_OUT;
        S_OUT:  if (status.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd      = '0;
    cmd.take = (state == S_IDLE) && in_valid;
    cmd.rd   = (state == S_READ);
    cmd.upd  = (state == S_GRAD);
    cmd.sq   = (state == S_SQ);
    cmd.step = (state == S_ROOT);
    cmd.load = (state == S_OUT) && status.out_free;
  end

endmodule

// File: src/sems_dp.sv
module sems_dp import sems_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic [PIX_W-1:0] in_pixel,
  input  logic             in_frame_start,
  input  dp_cmd_t          cmd,
  output dp_status_t       status,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_edge,
  output logic [POS_W-1:0] out_col,
  output logic [POS_W-1:0] out_row,
  output logic             out_last
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int XW = (AW > POS_W) ? AW : POS_W;

  logic [CFG_W-1:0] cfg_width;
  logic [CFG_W-1:0] cfg_height;
  logic [CW-1:0]    eff_w;
  logic [CFG_W-1:0] eff_h;

  logic [CW-1:0]    col_count;
  logic [POS_W-1:0] row_count;

  logic [CW-1:0]    c;
  logic [CFG_W-1:0] r13;
  logic [CFG_W-1:0] r;
  logic [CW-1:0]    c_inc;
  logic [CFG_W-1:0] r_inc;
  logic             wrap_in;

  logic [AW-1:0]    cur_c;
  logic [POS_W-1:0] cur_r;
  logic [PIX_W-1:0] cur_px;
  logic             cur_int;
  logic             cur_last;

  logic [PIX_W-1:0] mem_u [MAX_WIDTH];
  logic [PIX_W-1:0] mem_l [MAX_WIDTH];
  logic [PIX_W-1:0] top_q;
  logic [PIX_W-1:0] mid_q;
  logic [PIX_W-1:0] win [6];

  logic signed [GRAD_W-1:0] gx;
  logic signed [GRAD_W-1:0] gy;
  logic signed [GRAD_W-1:0] gx_c;
  logic signed [GRAD_W-1:0] gy_c;
  logic signed [SUM_W-1:0]  gx_w;
  logic signed [SUM_W-1:0]  gy_w;
  logic [SUM_W-1:0] sum;
  logic [PIX_W-1:0] root;
  logic [2:0]       idx;
  logic [PIX_W-1:0] trial;
  logic [2*PIX_W-1:0] trial_sq;
  logic [XW-1:0]    ccol_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= WIDTH_RST;
      cfg_height <= HEIGHT_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH) cfg_width <= cfg_data;
      else cfg_height <= cfg_data;
    end
  end

  always_comb begin
    if (cfg_width < DIM_MIN) eff_w = CW'(3);
    else if (32'(cfg_width) > MAX_WIDTH) eff_w = CW'(MAX_WIDTH);
    else eff_w = CW'(cfg_width);
    if (cfg_height < DIM_MIN) eff_h = DIM_MIN;
    else if (cfg_height > HEIGHT_MAX) eff_h = HEIGHT_MAX;
    else eff_h = cfg_height;
  end

  // position of the incoming pixel and of the one after it
  always_comb begin
    wrap_in = (col_count >= eff_w);
    if (in_frame_start) begin
      c   = '0;
      r13 = '0;
    end else if (wrap_in) begin
      c   = '0;
      r13 = CFG_W'(row_count) + 1'b1;
    end else begin
      c   = col_count;
      r13 = CFG_W'(row_count);
    end
    r     = (r13 >= eff_h) ? '0 : r13;
    c_inc = c + 1'b1;
    r_inc = r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cmd.take) begin
      if (c_inc >= eff_w) begin
        col_count <= '0;
        row_count <= (r_inc >= eff_h) ? '0 : r_inc[POS_W-1:0];
      end else begin
        col_count <= c_inc;
        row_count <= r[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_c    <= c[AW-1:0];
      cur_r    <= r[POS_W-1:0];
      cur_px   <= in_pixel;
      cur_int  <= (c >= CW'(2)) && (r >= CFG_W'(2));
      cur_last <= (c == eff_w - 1'b1) && (r == eff_h - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      top_q <= mem_u[cur_c];
      mid_q <= mem_l[cur_c];
    end
    if (cmd.upd) begin
      mem_u[cur_c] <= mid_q;
      mem_l[cur_c] <= cur_px;
    end
  end

  always_comb begin
    gx_c = (GRAD_W'(top_q) + (GRAD_W'(mid_q) << 1) + GRAD_W'(cur_px))
         - (GRAD_W'(win[0]) + (GRAD_W'(win[1]) << 1) + GRAD_W'(win[2]));
    gy_c = (GRAD_W'(win[2]) + (GRAD_W'(win[5]) << 1) + GRAD_W'(cur_px))
         - (GRAD_W'(win[0]) + (GRAD_W'(win[3]) << 1) + GRAD_W'(top_q));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else if (cmd.upd) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top_q;
      win[4] <= mid_q;
      win[5] <= cur_px;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      gx <= gx_c;
      gy <= gy_c;
    end
  end

  // sign-extend before squaring so the products keep every bit
  assign gx_w = SUM_W'(gx);
  assign gy_w = SUM_W'(gy);

  // bit-serial square root, most significant bit first
  assign trial    = root | (PIX_W'(1) << idx);
  assign trial_sq = trial * trial;

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      sum  <= gx_w * gx_w + gy_w * gy_w;
      root <= '0;
      idx  <= 3'd7;
    end else if (cmd.step) begin
      if (SUM_W'(trial_sq) <= sum) root <= trial;
      idx <= idx - 1'b1;
    end
  end

  assign ccol_x = XW'(cur_c) - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_edge <= root;
      out_col  <= ccol_x[POS_W-1:0];
      out_row  <= cur_r - 1'b1;
      out_last <= cur_last;
    end
  end

  assign status.interior  = cur_int;
  assign status.root_last = (idx == 3'd0);
  assign status.out_free  = !out_valid || out_ready;

endmodule

// File: src/sobel_edge_magnitude_stream_top.sv
// Streaming 3x3 Sobel edge magnitude.
// Channels: pix (sink) carries pixel and frame_start in raster order; res
// (source) carries edge_res, center_col, center_row and frame_last. A
// transaction completes at a rising edge with valid and ready both high.
// Configuration: write cfg_we with cfg_index (0 = image width, 1 = image
// height) and cfg_data; write only while the block is idle.
// Throughput: one pixel at a time. A border pixel goes through accept,
// line-store read and window update. An interior pixel goes through accept,
// read, gradient, sum of squares, 8 square-root steps (one result bit per
// cycle through an 8x8 multiplier) and load into the output register. The
// root iteration sets the rate.
// The output register is separate from the pipeline: a new pixel is taken
// while a result still waits. If the receiver stalls, hold the result and
// stop before loading the next one.
// Reset: position counters go to row 0 column 0, width 640, height 480,
// window cleared; line stores hold whatever they held and need no clearing.
module sobel_edge_magnitude_stream_top import sems_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  sems_pix_if.sink         pix,
  sems_res_if.source       res
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: one pixel in flight
  sems_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix.valid),
    .in_ready (pix.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // line stores, window, gradient and root unit
  sems_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_pixel       (pix.pixel),
    .in_frame_start (pix.frame_start),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (res.valid),
    .out_ready      (res.ready),
    .out_edge       (res.edge_res),
    .out_col        (res.center_col),
    .out_row        (res.center_row),
    .out_last       (res.frame_last)
  );

endmodule

// File: src/sems_checker.sv
module sems_checker import sems_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [POS_W-1:0] out_col,
  input logic [POS_W-1:0] out_row
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_col: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_col != '0)
    else $error("border column reported");

  a_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_row != '0)
    else $error("border row reported");

endmodule

bind sobel_edge_magnitude_stream_top sems_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .out_col   (res.center_col),
  .out_row   (res.center_row)
);
